// ===== rtl/core/lzss_stream_decoder_macros.svh =====
// Assertion macros for the LZSS stream decoder checkers.
// Used by lsd_checker.sv; no other dependencies.
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH

// same-cycle implication, reset masks the check
`define LSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define LSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lsd_pkg.sv =====
// Shared types and constants of the LZSS stream decoder.
// No dependencies; imported by the window, parser, top level, checker and testbench.
`default_nettype none

package lsd_pkg;

	localparam int WIN_AW = 12;                      // 4096-entry history window
	localparam int HI_CNT = 18;                      // entries above the initial fill
	localparam int HI_AW  = 5;
	localparam int LEN_W  = 5;                       // copy length 3..18

	localparam logic [WIN_AW-1:0] WP_INIT    = 12'd4078;
	localparam logic [WIN_AW:0]   FILL_MAX   = 13'd4096;
	localparam logic [LEN_W-1:0]  MIN_MATCH  = 5'd3;
	localparam logic [3:0]        FLAG_BITS  = 4'd8;
	localparam logic [7:0]        SPACE_BYTE = 8'h20;
	localparam logic [7:0]        ZERO_BYTE  = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} lsd_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} lsd_out_t;

	// parser to window: one read or one literal per cycle while stage 1 is free, plus stream restart
	typedef struct packed {
		logic              rd_en;
		logic [WIN_AW-1:0] rd_addr;
		logic              rd_last;
		logic              lit_en;
		logic [7:0]        lit_byte;
		logic              start;
	} lsd_req_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_ITEM,
		PH_HIGH
	} lsd_phase_t;

	// where the byte held in stage 1 comes from
	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_REG,
		SRC_SPACE,
		SRC_ZERO
	} lsd_src_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsd_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module lsd_ram #(
	parameter int unsigned Depth = 4096,
	parameter int unsigned Width = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/lsd_window.sv =====
// History window: RAM, write pointer, fill tracking and the read stage.
// Depends on lsd_pkg and lsd_ram.
`default_nettype none

module lsd_window (
	input  logic              clk,
	input  logic              arst_n,
	input  lsd_pkg::lsd_req_t req,
	input  logic              adv,
	output logic              s1_valid,
	output lsd_pkg::lsd_out_t s1_item
);

	import lsd_pkg::*;

	logic [WIN_AW-1:0] wp_q;
	logic [WIN_AW:0]   fill_q;
	logic              started_q;
	logic [HI_CNT-1:0] hi_valid_q;

	logic              s1_valid_q;
	lsd_src_t          src_s1;
	logic [7:0]        dat_s1;
	logic              last_s1;

	logic [7:0]        ram_rdata;
	logic              wr_en;
	logic [7:0]        wr_data;
	logic [WIN_AW-1:0] wr_off;
	logic              wr_hi;
	logic [WIN_AW-1:0] rd_off;
	logic              rd_hi;
	logic              rd_in_fill;
	logic              rd_fwd;
	lsd_src_t          rd_src;

	lsd_ram #(
		.Depth(1 << WIN_AW),
		.Width(8)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wp_q),
		.wr_data(wr_data),
		.rd_en  (req.rd_en),
		.rd_addr(req.rd_addr),
		.rd_data(ram_rdata)
	);

	// byte leaving stage 1 goes both to the output and back into the window
	assign wr_en = adv && s1_valid_q;

	always_comb begin
		unique case (src_s1)
			SRC_MEM:   wr_data = ram_rdata;
			SRC_REG:   wr_data = dat_s1;
			SRC_SPACE: wr_data = SPACE_BYTE;
			SRC_ZERO:  wr_data = ZERO_BYTE;
		endcase
	end

	assign wr_off = wp_q - WP_INIT;
	assign wr_hi  = wp_q >= WP_INIT;

	// entries written since the last restart form a run starting at WP_INIT
	assign rd_off     = req.rd_addr - WP_INIT;
	assign rd_hi      = req.rd_addr >= WP_INIT;
	assign rd_in_fill = {1'b0, rd_off} < fill_q;
	// read of the entry written this same cycle: RAM returns stale data
	assign rd_fwd     = wr_en && (req.rd_addr == wp_q);

	always_comb begin
		if (rd_fwd) begin
			rd_src = SRC_REG;
		end else if (rd_in_fill) begin
			rd_src = SRC_MEM;
		end else if (rd_hi) begin
			rd_src = hi_valid_q[rd_off[HI_AW-1:0]] ? SRC_MEM : SRC_ZERO;
		end else begin
			rd_src = started_q ? SRC_SPACE : SRC_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= WP_INIT;
			fill_q     <= '0;
			started_q  <= 1'b0;
			hi_valid_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				wp_q      <= WP_INIT;
				fill_q    <= '0;
				started_q <= 1'b1;
			end else if (wr_en) begin
				wp_q <= wp_q + 1'b1;
				if (fill_q != FILL_MAX) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			// top entries survive a restart, so track them since reset
			if (wr_en && wr_hi) begin
				hi_valid_q[wr_off[HI_AW-1:0]] <= 1'b1;
			end
			if (req.lit_en || req.rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.lit_en) begin
			src_s1  <= SRC_REG;
			dat_s1  <= req.lit_byte;
			last_s1 <= 1'b1;
		end else if (req.rd_en) begin
			src_s1  <= rd_src;
			dat_s1  <= wr_data;
			last_s1 <= req.rd_last;
		end
	end

	assign s1_valid         = s1_valid_q;
	assign s1_item.out_byte = wr_data;
	assign s1_item.run_last = last_s1;

endmodule

`default_nettype wire

// ===== rtl/core/lsd_parser.sv =====
// Stream parser: flag bits, literal and token decoding, copy address sequencer.
// Depends on lsd_pkg.
`default_nettype none

module lsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  lsd_pkg::lsd_in_t  item,
	input  logic              s1_free,
	output logic              busy,
	output lsd_pkg::lsd_req_t req
);

	import lsd_pkg::*;

	lsd_phase_t        phase_q, phase_d;
	logic [7:0]        bits_q, bits_d;
	logic [3:0]        left_q, left_d;
	logic [7:0]        low_q, low_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [WIN_AW-1:0] addr_q, addr_d;

	lsd_phase_t        eff_phase;
	logic [3:0]        eff_left;
	logic              rd_go;

	assign busy  = cnt_q != '0;
	assign rd_go = busy && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			bits_q  <= '0;
			left_q  <= '0;
			low_q   <= '0;
			cnt_q   <= '0;
			addr_q  <= '0;
		end else begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			left_q  <= left_d;
			low_q   <= low_d;
			cnt_q   <= cnt_d;
			addr_q  <= addr_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		left_d  = left_q;
		low_d   = low_q;
		cnt_d   = cnt_q;
		addr_d  = addr_q;

		req.rd_en    = rd_go;
		req.rd_addr  = addr_q;
		req.rd_last  = cnt_q == LEN_W'(1);
		req.lit_en   = 1'b0;
		req.lit_byte = item.in_byte;
		req.start    = accept && item.stream_start;

		// a restart makes the byte a flag byte
		eff_phase = item.stream_start ? PH_FLAG : phase_q;
		eff_left  = item.stream_start ? 4'd0 : left_q;

		if (rd_go) begin
			cnt_d  = cnt_q - 1'b1;
			addr_d = addr_q + 1'b1;
		end

		if (accept) begin
			unique case (eff_phase)
				PH_HIGH: begin
					cnt_d   = LEN_W'(item.in_byte[3:0]) + MIN_MATCH;
					addr_d  = {item.in_byte[7:4], low_q};
					bits_d  = bits_q >> 1;
					left_d  = (eff_left != '0) ? eff_left - 1'b1 : 4'd0;
					phase_d = (left_d == '0) ? PH_FLAG : PH_ITEM;
				end
				PH_ITEM: begin
					if (eff_left == '0) begin
						bits_d  = item.in_byte;
						left_d  = FLAG_BITS;
						phase_d = PH_ITEM;
					end else if (bits_q[0]) begin
						req.lit_en = 1'b1;
						bits_d     = bits_q >> 1;
						left_d     = eff_left - 1'b1;
						phase_d    = (left_d == '0) ? PH_FLAG : PH_ITEM;
					end else begin
						low_d   = item.in_byte;
						phase_d = PH_HIGH;
					end
				end
				default: begin
					bits_d  = item.in_byte;
					left_d  = FLAG_BITS;
					phase_d = PH_ITEM;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lzss_stream_decoder.sv =====
// LZSS stream decoder, 4096-byte window. Flag, literal and first token bytes
// do not hold the input; a literal passes through stage 1 and the output
// register. The second byte of a match token of length L (3..18) holds the
// input while the window RAM's single read port streams the L bytes, one byte
// per cycle unless the output stalls. The window needs no clearing pass: a
// fill count since the last restart and valid bits for the 18 entries above
// the initial fill decide what unwritten entries read as. Overlapping copies
// are forwarded from the write port.
// Depends on lsd_pkg, lsd_parser and lsd_window.
`default_nettype none

module lzss_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmp_valid,
	output logic              cmp_stall,
	input  lsd_pkg::lsd_in_t  cmp_item,
	output logic              dec_valid,
	input  logic              dec_stall,
	output lsd_pkg::lsd_out_t dec_item
);

	import lsd_pkg::*;

	logic     dec_valid_q;
	lsd_out_t dec_item_q;
	logic     adv;
	logic     s1_valid;
	logic     s1_free;
	logic     busy;
	logic     accept;
	lsd_req_t req;
	lsd_out_t s1_item;

	assign adv       = !dec_valid_q || !dec_stall;
	assign s1_free   = !s1_valid || adv;
	assign cmp_stall = busy || !s1_free;
	assign accept    = cmp_valid && !cmp_stall;

	lsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (cmp_item),
		.s1_free(s1_free),
		.busy   (busy),
		.req    (req)
	);

	lsd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.adv     (adv),
		.s1_valid(s1_valid),
		.s1_item (s1_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid_q <= 1'b0;
		end else if (adv) begin
			dec_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			dec_item_q <= s1_item;
		end
	end

	assign dec_valid = dec_valid_q;
	assign dec_item  = dec_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/lsd_checker.sv =====
// Port-level checks for the LZSS stream decoder, bound to the top level.
// Depends on lsd_pkg and lzss_stream_decoder_macros.svh.
`default_nettype none

`include "lzss_stream_decoder_macros.svh"

module lsd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmp_valid,
	input wire logic              cmp_stall,
	input wire lsd_pkg::lsd_in_t  cmp_item,
	input wire logic              dec_valid,
	input wire logic              dec_stall,
	input wire lsd_pkg::lsd_out_t dec_item
);

	import lsd_pkg::*;

	logic cmp_take;

	assign cmp_take = cmp_valid && !cmp_stall;

	// a held input item stays put
	`LSD_ASSERT_NXT(a_cmp_hold, clk, arst_n, cmp_valid && cmp_stall, cmp_valid && $stable(cmp_item), "input item changed while stalled")

	// a held output item stays put
	`LSD_ASSERT_NXT(a_dec_hold, clk, arst_n, dec_valid && dec_stall, dec_valid && $stable(dec_item), "output item changed while stalled")

	// inside a copy run the next byte follows at once
	`LSD_ASSERT_NXT(a_run_gapless, clk, arst_n, dec_valid && !dec_stall && !dec_item.run_last, dec_valid, "gap inside a copy run")

	// input held back with an empty output means a copy is streaming
	`LSD_ASSERT_IMP(a_stall_progress, clk, arst_n, cmp_stall && !dec_valid && !cmp_take, ##2 dec_valid, "input stalled without output progress")

endmodule

bind lzss_stream_decoder lsd_checker u_lsd_checker (.*);

`default_nettype wire

// ===== tb/lzss_stream_decoder_test.sv =====
// Self-checking testbench for lzss_stream_decoder: directed table, then random
// LZSS streams, each result checked against the table's expected bytes or an in-line decoder model.
// Depends on lsd_pkg and the lzss_stream_decoder RTL.
`timescale 1ns / 1ps

module lzss_stream_decoder_test;

	import lsd_pkg::*;

	localparam int N_DIRECTED  = 24;
	localparam int N_RANDOM    = 356;
	localparam int MAX_GAP     = 18;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN       = 60;

	typedef struct {
		lsd_in_t    item;
		int         known_n;    // -1: results come from the decoder model
		logic [7:0] known_byte;
	} row_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     cmp_valid = 1'b0;
	logic     cmp_stall;
	lsd_in_t  cmp_item  = '0;
	logic     dec_valid;
	logic     dec_stall = 1'b0;
	lsd_out_t dec_item;

	// decoder model state
	logic [7:0]  window [4096];
	logic [11:0] wr_ptr;
	logic [7:0]  ctl_bits;
	logic [3:0]  ctl_left;
	lsd_phase_t  phase;
	logic [7:0]  low_byte;
	lsd_out_t    step_out [$];

	lsd_out_t pending_bytes [$];
	row_t     issued_rows [$];
	int       mismatches   = 0;
	int       items_sent   = 0;
	int       quiet_cycles = 0;
	int       stall_left   = 0;
	bit       in_burst     = 1'b0;
	bit       out_burst    = 1'b0;

	// flag bits, literals and tokens: first is low position byte, then high nibble | len-3
	row_t directed [N_DIRECTED] = '{
		'{{8'h00, 1'b0}, 0, 8'h00},   // flag without stream start: all tokens
		'{{8'h00, 1'b0}, 0, 8'h00},
		'{{8'h0F, 1'b0}, 18, 8'h00},  // longest copy from the zeroed window, wp wraps
		'{{8'hFF, 1'b0}, 0, 8'h00},
		'{{8'hF0, 1'b0}, 3, 8'h00},   // shortest copy, read position wraps
		'{{8'hFF, 1'b1}, 0, 8'h00},   // stream start, all literals
		'{{8'h00, 1'b0}, 1, 8'h00},
		'{{8'hFF, 1'b0}, 1, 8'hFF},
		'{{8'h55, 1'b0}, 1, 8'h55},
		'{{8'hAA, 1'b0}, 1, 8'hAA},
		'{{8'h01, 1'b0}, 1, 8'h01},
		'{{8'h80, 1'b0}, 1, 8'h80},
		'{{8'h7E, 1'b0}, 1, 8'h7E},
		'{{8'h81, 1'b0}, 1, 8'h81},
		'{{8'h00, 1'b0}, 0, 8'h00},
		'{{8'h00, 1'b0}, 0, 8'h00},
		'{{8'h0F, 1'b0}, 18, 8'h20},  // spaces from the filled region
		'{{8'hEE, 1'b0}, 0, 8'h00},
		'{{8'hF5, 1'b0}, -1, 8'h00},  // replay the literals kept above the fill
		'{{8'h0F, 1'b0}, 0, 8'h00},
		'{{8'h04, 1'b0}, -1, 8'h00},  // source one behind wp: overlapping copy
		'{{8'h12, 1'b0}, 0, 8'h00},
		'{{8'h01, 1'b1}, 0, 8'h00},   // restart drops the half token
		'{{8'h33, 1'b0}, 1, 8'h33}
	};

	lzss_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmp_valid (cmp_valid),
		.cmp_stall (cmp_stall),
		.cmp_item  (cmp_item),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_item  (dec_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic take_bit();
		ctl_bits = ctl_bits >> 1;
		if (ctl_left != 0)
			ctl_left--;
		phase = (ctl_left == 0) ? PH_FLAG : PH_ITEM;
	endtask

	task automatic store_byte(input logic [7:0] b);
		lsd_out_t o;
		o.out_byte = b;
		o.run_last = 1'b0;
		step_out.push_back(o);
		window[wr_ptr] = b;
		wr_ptr++;
	endtask

	// decode one compressed byte into step_out
	task automatic decode_byte(input lsd_in_t item);
		logic [11:0] pos;
		int          len;
		int          k;
		step_out.delete();
		if (item.stream_start) begin
			for (k = 0; k < WP_INIT; k++)
				window[k] = SPACE_BYTE;
			wr_ptr   = WP_INIT;
			ctl_bits = '0;
			ctl_left = '0;
			phase    = PH_FLAG;
			low_byte = '0;
		end
		if (phase == PH_HIGH) begin
			pos = {item.in_byte[7:4], low_byte};
			len = item.in_byte[3:0] + MIN_MATCH;
			for (k = 0; k < len; k++)
				store_byte(window[12'(pos + k)]);
			take_bit();
		end else if (phase == PH_ITEM && ctl_left != 0) begin
			if (ctl_bits[0]) begin
				store_byte(item.in_byte);
				take_bit();
			end else begin
				low_byte = item.in_byte;
				phase    = PH_HIGH;
			end
		end else begin
			ctl_bits = item.in_byte;
			ctl_left = FLAG_BITS;
			phase    = PH_ITEM;
		end
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].run_last = 1'b1;
	endtask

	task automatic send_item(input lsd_in_t item, input int known_n, input logic [7:0] known_byte);
		row_t r;
		int   gap;
		r.item       = item;
		r.known_n    = known_n;
		r.known_byte = known_byte;
		if ($urandom_range(0, 39) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		issued_rows.push_back(r);
		cmp_item  <= item;
		cmp_valid <= 1'b1;
		do @(posedge clk); while (cmp_stall);
		items_sent++;
	endtask

	// input and output acceptance, checking and output stall
	always @(posedge clk) begin : monitor
		row_t     r;
		lsd_out_t want;
		lsd_out_t o;
		int       i;
		if (arst_n) begin
			if (cmp_valid && !cmp_stall) begin
				r = issued_rows.pop_front();
				decode_byte(r.item);
				if (r.known_n < 0) begin
					foreach (step_out[i])
						pending_bytes.push_back(step_out[i]);
				end else begin
					for (i = 0; i < r.known_n; i++) begin
						o.out_byte = r.known_byte;
						o.run_last = (i == r.known_n - 1);
						pending_bytes.push_back(o);
					end
				end
			end
			if (dec_valid && !dec_stall) begin
				if (pending_bytes.size() == 0) begin
					$display("%0t: unexpected item: expected none, got out_byte %02h run_last %b",
						$time, dec_item.out_byte, dec_item.run_last);
					mismatches++;
				end else begin
					want = pending_bytes.pop_front();
					if (want.out_byte !== dec_item.out_byte) begin
						$display("%0t: out_byte expected %02h, got %02h",
							$time, want.out_byte, dec_item.out_byte);
						mismatches++;
					end
					if (want.run_last !== dec_item.run_last) begin
						$display("%0t: run_last expected %b, got %b",
							$time, want.run_last, dec_item.run_last);
						mismatches++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					out_burst = !out_burst;
				stall_left = out_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall_left > 0) begin
				dec_stall <= 1'b1;
				stall_left--;
			end else begin
				dec_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmp_valid && !cmp_stall) || (dec_valid && !dec_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("lzss_stream_decoder: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int          i;
		int          g;
		int          b;
		int          groups;
		int          len_code;
		int          junk;
		logic [7:0]  flags;
		logic [11:0] pos;
		logic [11:0] gen_wp;
		bit          restart;
		bit          fresh;
		bit          cut;

		for (i = 0; i < 4096; i++)
			window[i] = ZERO_BYTE;
		wr_ptr   = WP_INIT;
		ctl_bits = '0;
		ctl_left = '0;
		phase    = PH_FLAG;
		low_byte = '0;
		gen_wp   = WP_INIT;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].item, directed[i].known_n, directed[i].known_byte);

		// random streams; a cut stream or noise forces a restart to resync
		fresh = 1'b1;
		while (items_sent < N_DIRECTED + N_RANDOM) begin
			restart = fresh || ($urandom_range(0, 9) != 0);
			fresh   = 1'b0;
			cut     = 1'b0;
			if (restart)
				gen_wp = WP_INIT;
			groups = $urandom_range(1, 4);
			for (g = 0; g < groups && !cut; g++) begin
				flags = 8'($urandom_range(0, 255));
				send_item({flags, restart && g == 0}, -1, 8'h00);
				for (b = 0; b < 8 && !cut; b++) begin
					cut = ($urandom_range(0, 24) == 0);
					if (flags[b]) begin
						if (!cut) begin
							send_item({8'($urandom_range(0, 255)), 1'b0}, -1, 8'h00);
							gen_wp++;
						end
					end else begin
						case ($urandom_range(0, 4))
							0: pos = 12'($urandom_range(0, 4095));
							1: pos = 12'hFF0 + 12'($urandom_range(0, 15));
							default: pos = 12'(gen_wp - $urandom_range(1, 24));
						endcase
						len_code = $urandom_range(0, 15);
						send_item({pos[7:0], 1'b0}, -1, 8'h00);
						if (!cut) begin
							send_item({pos[11:8], len_code[3:0], 1'b0}, -1, 8'h00);
							gen_wp = gen_wp + 12'(len_code + 3);
						end
					end
				end
			end
			fresh = cut;
			if ($urandom_range(0, 7) == 0) begin
				junk = $urandom_range(1, 4);
				repeat (junk) send_item({8'($urandom_range(0, 255)), 1'b0}, -1, 8'h00);
				fresh = 1'b1;
			end
		end
		cmp_valid <= 1'b0;
		@(posedge clk);

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0) begin
			$display("lzss_stream_decoder: match");
		end else begin
			$display("lzss_stream_decoder: mismatch");
		end
		$finish;
	end

endmodule
